// ===== hw/rtl/scfp_pkg.sv =====
// Shared types and constants of the serial command frame parser.
package scfp_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned EVT_W = 4;
	localparam int unsigned PHASE_W = 3;
	localparam int unsigned CFG_ADDR_W = 1;
	localparam int unsigned OUT_DATA_W = 40;

	localparam logic [BYTE_W-1:0] MAX_LENGTH_RESET = 8'd150;
	localparam logic [BYTE_W-1:0] HEADER_RESET = 8'd0;

	// Register indexes of the write port.
	localparam logic [CFG_ADDR_W-1:0] REG_HEADER_BYTE = 1'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_MAX_LENGTH = 1'd1;

	// Parser phases.
	localparam logic [PHASE_W-1:0] PH_HUNT = 3'd0;
	localparam logic [PHASE_W-1:0] PH_ADDRESS = 3'd1;
	localparam logic [PHASE_W-1:0] PH_COMMAND = 3'd2;
	localparam logic [PHASE_W-1:0] PH_LENGTH = 3'd3;
	localparam logic [PHASE_W-1:0] PH_PAYLOAD = 3'd4;
	localparam logic [PHASE_W-1:0] PH_CHECKSUM = 3'd5;

	// Event codes.
	localparam logic [EVT_W-1:0] EV_SKIPPED = 4'd0;
	localparam logic [EVT_W-1:0] EV_HEADER = 4'd1;
	localparam logic [EVT_W-1:0] EV_ADDRESS = 4'd2;
	localparam logic [EVT_W-1:0] EV_COMMAND = 4'd3;
	localparam logic [EVT_W-1:0] EV_LENGTH_OK = 4'd4;
	localparam logic [EVT_W-1:0] EV_PAYLOAD = 4'd5;
	localparam logic [EVT_W-1:0] EV_FRAME_OK = 4'd6;
	localparam logic [EVT_W-1:0] EV_CHECKSUM_BAD = 4'd7;
	localparam logic [EVT_W-1:0] EV_LENGTH_BAD = 4'd8;

	typedef struct packed {
		logic [PHASE_W-1:0] phase;
		logic [BYTE_W-1:0] running_sum;
		logic [BYTE_W-1:0] byte_position;
		logic [BYTE_W-1:0] payload_length;
		logic [BYTE_W-1:0] address_seen;
		logic [BYTE_W-1:0] command_seen;
	} frame_state_t;

	typedef struct packed {
		logic [EVT_W-1:0] event_res;
		logic [BYTE_W-1:0] data_byte;
		logic [BYTE_W-1:0] payload_index;
		logic last_payload;
		logic [BYTE_W-1:0] frame_address;
		logic [BYTE_W-1:0] frame_command;
		logic [BYTE_W-1:0] frame_length;
	} frame_result_t;

	localparam frame_state_t FRAME_STATE_CLEAR = '{
		phase: PH_HUNT,
		running_sum: '0,
		byte_position: '0,
		payload_length: '0,
		address_seen: '0,
		command_seen: '0
	};

endpackage

// ===== hw/rtl/scfp_step.sv =====
// Next-state and event logic of the frame parser for one received byte.
module scfp_step (
	input  scfp_pkg::frame_state_t     cur,
	input  logic [7:0]                 rx_byte,
	input  logic [7:0]                 header_byte,
	input  logic [7:0]                 max_length,
	output scfp_pkg::frame_state_t     nxt,
	output scfp_pkg::frame_result_t    res
);
	import scfp_pkg::*;

	frame_state_t upd;
	logic [BYTE_W-1:0] sum_plus;
	logic [BYTE_W-1:0] pos_plus;
	logic [EVT_W-1:0] evt;
	logic [BYTE_W-1:0] idx;
	logic last;
	logic done;

	assign sum_plus = cur.running_sum + rx_byte;
	assign pos_plus = cur.byte_position + 8'd1;

	always_comb begin
		upd = cur;
		evt = EV_SKIPPED;
		idx = '0;
		last = 1'b0;
		done = 1'b0;
		case (cur.phase)
			PH_HUNT: begin
				if (rx_byte == header_byte) begin
					upd.running_sum = sum_plus;
					upd.byte_position = '0;
					upd.phase = PH_ADDRESS;
					evt = EV_HEADER;
				end
			end
			PH_ADDRESS: begin
				upd.address_seen = rx_byte;
				upd.running_sum = sum_plus;
				upd.phase = PH_COMMAND;
				evt = EV_ADDRESS;
			end
			PH_COMMAND: begin
				upd.command_seen = rx_byte;
				upd.running_sum = sum_plus;
				upd.phase = PH_LENGTH;
				evt = EV_COMMAND;
			end
			PH_LENGTH: begin
				if (rx_byte == '0 || rx_byte > max_length) begin
					evt = EV_LENGTH_BAD;
					done = 1'b1;
				end else begin
					upd.payload_length = rx_byte;
					upd.running_sum = sum_plus;
					upd.phase = PH_PAYLOAD;
					evt = EV_LENGTH_OK;
				end
			end
			PH_PAYLOAD: begin
				if (cur.byte_position < cur.payload_length) begin
					idx = cur.byte_position;
					upd.running_sum = sum_plus;
					upd.byte_position = pos_plus;
					if (pos_plus >= cur.payload_length) begin
						last = 1'b1;
						upd.phase = PH_CHECKSUM;
					end
					evt = EV_PAYLOAD;
				end else begin
					done = 1'b1;
				end
			end
			PH_CHECKSUM: begin
				evt = (cur.running_sum == rx_byte) ? EV_FRAME_OK : EV_CHECKSUM_BAD;
				done = 1'b1;
			end
			default: begin
				done = 1'b1;
			end
		endcase
	end

	// Verdicts report the fields held before the parser clears.
	always_comb begin
		res.event_res = evt;
		res.data_byte = rx_byte;
		res.payload_index = idx;
		res.last_payload = last;
		res.frame_address = upd.address_seen;
		res.frame_command = upd.command_seen;
		res.frame_length = upd.payload_length;
		nxt = done ? FRAME_STATE_CLEAR : upd;
	end

endmodule

// ===== hw/rtl/serial_command_frame_parser.sv =====
// Top level of the serial command frame parser: input register, parse step, result register.
// A byte accepted into the input register passes through scfp_step into the result register.
// One byte per cycle while the result is taken; the parser state loop closes through scfp_step.
// The input stalls only when both registers hold a request and the result is not taken.
// Reset (arst_n low, asynchronous) empties both registers, returns the parser to hunting,
// and sets header_byte to 0 and max_length to 150.
module serial_command_frame_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [scfp_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [7:0]  cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] data_byte, [15:8] payload_index, [23:16] frame_address,
	// [31:24] frame_command, [39:32] frame_length
	output logic [scfp_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic [3:0]  m_tuser,   // [3:0] event_res
	output logic        m_tlast    // last_payload
);
	import scfp_pkg::*;

	logic [BYTE_W-1:0] header_byte_q;
	logic [BYTE_W-1:0] max_length_q;
	logic valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	frame_state_t state_q;
	frame_state_t state_nxt;
	frame_result_t res;
	frame_result_t res_s2;
	logic valid_s2;
	logic adv;

	// The result register takes a new event when it is empty or being drained.
	assign adv = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_byte_q <= HEADER_RESET;
			max_length_q <= MAX_LENGTH_RESET;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_HEADER_BYTE: header_byte_q <= cfg_wdata;
				REG_MAX_LENGTH: max_length_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	scfp_step u_step (
		.cur        (state_q),
		.rx_byte    (byte_s1),
		.header_byte(header_byte_q),
		.max_length (max_length_q),
		.nxt        (state_nxt),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FRAME_STATE_CLEAR;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser = res_s2.event_res;
	assign m_tlast = res_s2.last_payload;
	assign m_tdata = {res_s2.frame_length, res_s2.frame_command, res_s2.frame_address,
		res_s2.payload_index, res_s2.data_byte};

	// A last mark or a nonzero index belongs only to a payload event.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser == EV_PAYLOAD)
		else $error("last mark on a non-payload event");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != EV_PAYLOAD |-> res_s2.payload_index == '0)
		else $error("payload index on a non-payload event");

	// After a verdict is produced the parser is back to hunting with a clear sum.
	assert property (@(posedge clk) disable iff (!arst_n)
		adv && valid_s1 && (res.event_res == EV_FRAME_OK || res.event_res == EV_CHECKSUM_BAD
		|| res.event_res == EV_LENGTH_BAD)
		|=> state_q.phase == PH_HUNT && state_q.running_sum == '0)
		else $error("parser not cleared after verdict");

	// The payload counter never runs past the accepted length.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q.byte_position <= state_q.payload_length)
		else $error("payload position beyond length");

endmodule

// ===== bench/serial_command_frame_parser_tb.sv =====
// Self-checking testbench for the serial command frame parser.
`timescale 1ns / 1ps

module serial_command_frame_parser_tb;
	import scfp_pkg::*;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = REG_HEADER_BYTE;
	logic [7:0]            cfg_wdata = 8'h00;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [7:0]            s_tdata = 8'h00;   // [7:0] rx_byte
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	// [7:0] data_byte, [15:8] payload_index, [23:16] frame_address,
	// [31:24] frame_command, [39:32] frame_length
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [3:0]            m_tuser;           // [3:0] event_res
	logic                  m_tlast;

	serial_command_frame_parser uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// Parser copy kept by the bench, along with its register settings.
	frame_state_t  parse_st = FRAME_STATE_CLEAR;
	logic [7:0]    header_cfg = HEADER_RESET;
	logic [7:0]    max_len_cfg = MAX_LENGTH_RESET;

	logic [7:0]    rx_bytes_q[$];
	frame_result_t events_due_q[$];
	frame_result_t want_res;
	frame_result_t got_res;
	int            mismatch_cnt = 0;
	int            bytes_queued = 0;
	bit            byte_taken = 0;
	bit            idle_on = 1;
	int            src_gap = 0;
	int            sink_gap = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic frame_result_t parse_byte(logic [7:0] b);
		frame_result_t r;
		bit            drop;
		r = '0;
		r.event_res = EV_SKIPPED;
		r.data_byte = b;
		drop = 0;
		case (parse_st.phase)
			PH_HUNT: begin
				if (b == header_cfg) begin
					parse_st.running_sum = parse_st.running_sum + b;
					parse_st.byte_position = '0;
					parse_st.phase = PH_ADDRESS;
					r.event_res = EV_HEADER;
				end
			end
			PH_ADDRESS: begin
				parse_st.address_seen = b;
				parse_st.running_sum = parse_st.running_sum + b;
				parse_st.phase = PH_COMMAND;
				r.event_res = EV_ADDRESS;
			end
			PH_COMMAND: begin
				parse_st.command_seen = b;
				parse_st.running_sum = parse_st.running_sum + b;
				parse_st.phase = PH_LENGTH;
				r.event_res = EV_COMMAND;
			end
			PH_LENGTH: begin
				if (b == 8'd0 || b > max_len_cfg) begin
					r.event_res = EV_LENGTH_BAD;
					drop = 1;
				end else begin
					parse_st.payload_length = b;
					parse_st.running_sum = parse_st.running_sum + b;
					parse_st.phase = PH_PAYLOAD;
					r.event_res = EV_LENGTH_OK;
				end
			end
			PH_PAYLOAD: begin
				if (parse_st.byte_position < parse_st.payload_length) begin
					r.payload_index = parse_st.byte_position;
					parse_st.running_sum = parse_st.running_sum + b;
					parse_st.byte_position = parse_st.byte_position + 8'd1;
					if (parse_st.byte_position >= parse_st.payload_length) begin
						r.last_payload = 1'b1;
						parse_st.phase = PH_CHECKSUM;
					end
					r.event_res = EV_PAYLOAD;
				end else begin
					drop = 1;
				end
			end
			PH_CHECKSUM: begin
				r.event_res = (parse_st.running_sum == b) ? EV_FRAME_OK : EV_CHECKSUM_BAD;
				drop = 1;
			end
			default: drop = 1;
		endcase
		// Verdicts still report the fields of the frame being closed.
		r.frame_address = parse_st.address_seen;
		r.frame_command = parse_st.command_seen;
		r.frame_length = parse_st.payload_length;
		if (drop)
			parse_st = FRAME_STATE_CLEAR;
		return r;
	endfunction

	task automatic queue_byte(logic [7:0] b);
		rx_bytes_q.push_back(b);
		bytes_queued++;
	endtask

	// A frame with the current header; it stops after the length byte when that is rejected.
	task automatic queue_frame(logic [7:0] addr, logic [7:0] cmd, logic [7:0] len, bit good);
		logic [7:0] sum;
		logic [7:0] pb;
		sum = header_cfg + addr + cmd + len;
		queue_byte(header_cfg);
		queue_byte(addr);
		queue_byte(cmd);
		queue_byte(len);
		if (len == 8'd0 || len > max_len_cfg)
			return;
		for (int i = 0; i < len; i++) begin
			pb = 8'($urandom_range(0, 255));
			sum = sum + pb;
			queue_byte(pb);
		end
		queue_byte(good ? sum : sum + 8'($urandom_range(1, 255)));
	endtask

	// Mostly well-formed frames with random content, mixed with noise and bad lengths.
	task automatic queue_random(int count);
		int start;
		int sel;
		int len_cap;
		int len;
		start = bytes_queued;
		while (bytes_queued - start < count) begin
			sel = $urandom_range(0, 9);
			len_cap = (max_len_cfg == 0) ? 8 : ((max_len_cfg < 8) ? max_len_cfg : 8);
			len = $urandom_range(1, len_cap);
			if (max_len_cfg != 0 && $urandom_range(0, 15) == 0)
				len = $urandom_range(1, max_len_cfg);
			if (sel == 0)
				queue_byte(8'($urandom_range(0, 255)));
			else if (sel == 1)
				queue_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			else
				queue_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8'(len),
					$urandom_range(0, 4) != 0);
		end
	endtask

	task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [7:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_HEADER_BYTE: header_cfg = val;
			REG_MAX_LENGTH:  max_len_cfg = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Checked at the rising edge, where the driver's outputs are settled.
	task automatic drain();
		while (rx_bytes_q.size() != 0 || s_tvalid || events_due_q.size() != 0)
			@(posedge clk);
	endtask

	// Request side: a new byte is offered once the previous one has been taken.
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			events_due_q.push_back(parse_byte(s_tdata));
			byte_taken = 1;
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (byte_taken || !s_tvalid) begin
			byte_taken = 0;
			if (src_gap > 0) begin
				src_gap--;
				s_tvalid <= 1'b0;
			end else if (rx_bytes_q.size() != 0) begin
				s_tdata <= rx_bytes_q.pop_front();
				s_tvalid <= 1'b1;
				if (idle_on && $urandom_range(0, 7) == 0)
					src_gap = $urandom_range(1, 9);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (sink_gap > 0) begin
			sink_gap--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if (idle_on && $urandom_range(0, 9) == 0)
				sink_gap = $urandom_range(1, 9);
		end
	end

	task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatch_cnt++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_res.event_res = m_tuser;
			got_res.data_byte = m_tdata[7:0];
			got_res.payload_index = m_tdata[15:8];
			got_res.last_payload = m_tlast;
			got_res.frame_address = m_tdata[23:16];
			got_res.frame_command = m_tdata[31:24];
			got_res.frame_length = m_tdata[39:32];
			if (events_due_q.size() == 0) begin
				$display("%0t: unexpected event, expected none, actual event %0h data %0h",
					$time, got_res.event_res, got_res.data_byte);
				mismatch_cnt++;
			end else begin
				want_res = events_due_q.pop_front();
				check_field("event_res", {4'd0, want_res.event_res},
					{4'd0, got_res.event_res});
				check_field("data_byte", want_res.data_byte, got_res.data_byte);
				check_field("payload_index", want_res.payload_index, got_res.payload_index);
				check_field("last_payload", {7'd0, want_res.last_payload},
					{7'd0, got_res.last_payload});
				check_field("frame_address", want_res.frame_address, got_res.frame_address);
				check_field("frame_command", want_res.frame_command, got_res.frame_command);
				check_field("frame_length", want_res.frame_length, got_res.frame_length);
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: header 0, max length 150.
		queue_byte(8'h37);
		queue_frame(8'hFF, 8'h00, 8'd1, 1);
		queue_frame(8'h00, 8'hFF, 8'd2, 0);
		queue_frame(8'h12, 8'h34, 8'd0, 1);
		queue_frame(8'h56, 8'h78, 8'd151, 1);
		queue_frame(8'h9A, 8'hBC, 8'd255, 1);
		queue_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8'd150, 1);
		queue_random(20);
		// Leave a frame open so the length check runs against the next setting.
		queue_frame(8'hA5, 8'h5A, 8'd0, 1);
		rx_bytes_q.pop_back();
		bytes_queued--;
		drain();

		// The open frame takes the largest length, so its payload reaches the last index.
		write_reg(REG_HEADER_BYTE, 8'hFF);
		write_reg(REG_MAX_LENGTH, 8'd255);
		queue_byte(8'd255);
		repeat (256) queue_byte(8'($urandom_range(0, 255)));
		queue_random(20);
		drain();

		write_reg(REG_HEADER_BYTE, 8'h5A);
		write_reg(REG_MAX_LENGTH, 8'd1);
		queue_frame(8'h01, 8'h02, 8'd2, 1);
		queue_random(30);
		drain();

		// A zero maximum rejects every length byte.
		write_reg(REG_HEADER_BYTE, 8'h00);
		write_reg(REG_MAX_LENGTH, 8'd0);
		queue_random(20);
		drain();

		write_reg(REG_HEADER_BYTE, 8'($urandom_range(0, 255)));
		write_reg(REG_MAX_LENGTH, 8'($urandom_range(1, 255)));
		idle_on = 0;
		queue_random(40);
		drain();

		repeat (10) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#1000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
